>>> rtl/ars_pkg.sv
// Shared types and fixed field widths for the audio running statistics block.
`default_nettype none

package ars_pkg;

  localparam int unsigned SAMPLE_W    = 32;  // width of every sample-sized field
  localparam int unsigned ACC_W       = 64;  // width of every sum field
  localparam int unsigned COUNT_OUT_W = 48;  // width of the reported sample count
  localparam int unsigned WIDE_W      = ACC_W + 1;  // unsigned sum plus carry

  typedef logic signed [SAMPLE_W-1:0]    sample_t;
  typedef logic        [SAMPLE_W-1:0]    mag_t;
  typedef logic signed [ACC_W-1:0]       acc_s_t;
  typedef logic        [ACC_W-1:0]       acc_u_t;
  typedef logic        [COUNT_OUT_W-1:0] count_t;

  // One sample after the front stages: magnitudes and squares already formed.
  typedef struct packed {
    sample_t raw;      // input bits, untouched
    sample_t sample;   // sign-extended from the configured sample width
    mag_t    mag;      // |sample|
    mag_t    step;     // |sample - previous sample|, zero on the first sample
    acc_u_t  mag_sq;   // mag * mag
    acc_u_t  step_sq;  // step * step
    logic    first;    // first sample since reset
  } ars_item_t;

endpackage

`default_nettype wire

>>> rtl/ars_in_if.sv
// Input sample channel: valid/ready handshake carrying one PCM sample.
`default_nettype none

interface ars_in_if;
  logic             valid;
  logic             ready;
  ars_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

>>> rtl/ars_out_if.sv
// Result channel: valid/ready handshake carrying the sample and its statistics.
`default_nettype none

interface ars_out_if;
  logic             valid;
  logic             ready;
  ars_pkg::sample_t sample_out;
  ars_pkg::sample_t minimum;
  ars_pkg::sample_t maximum;
  ars_pkg::sample_t midline;
  ars_pkg::acc_s_t  total_sum;
  ars_pkg::acc_u_t  magnitude_sum;
  ars_pkg::acc_u_t  power_sum;
  ars_pkg::mag_t    step_max;
  ars_pkg::acc_u_t  step_sum;
  ars_pkg::acc_u_t  step_power_sum;
  ars_pkg::count_t  samples_seen;
  logic             overflowed;

  modport source (
    output valid, output sample_out, output minimum, output maximum, output midline,
    output total_sum, output magnitude_sum, output power_sum, output step_max,
    output step_sum, output step_power_sum, output samples_seen, output overflowed,
    input ready
  );
  modport sink (
    input valid, input sample_out, input minimum, input maximum, input midline,
    input total_sum, input magnitude_sum, input power_sum, input step_max,
    input step_sum, input step_power_sum, input samples_seen, input overflowed,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/ars_prep.sv
// Front stages: input register, then magnitudes, step and squares into a product register.
`default_nettype none

module ars_prep #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  ars_in_if.sink             in_ch,
  output ars_pkg::ars_item_t item,
  output logic               item_valid,
  input  logic               item_ready
);
  import ars_pkg::*;

  localparam int unsigned PROD_W = 2 * SAMPLE_BITS;

  logic                        s1_valid_r;
  sample_t                     s1_raw_r;
  logic                        s1_go;
  logic                        seen_r;
  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic                        item_valid_r;
  ars_item_t                   item_r;
  ars_item_t                   item_nxt;

  logic signed [SAMPLE_BITS-1:0] s_cur;
  logic signed [SAMPLE_BITS:0]   s_wide;
  logic signed [SAMPLE_BITS:0]   s_neg;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS:0]   diff_neg;
  logic        [SAMPLE_BITS-1:0] mag;
  logic        [SAMPLE_BITS-1:0] step_mag;
  logic        [PROD_W-1:0]      mag_sq;
  logic        [PROD_W-1:0]      step_sq;

  assign s1_go       = s1_valid_r && (!item_valid_r || item_ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign item        = item_r;
  assign item_valid  = item_valid_r;

  always_comb begin
    s_cur    = signed'(s1_raw_r[SAMPLE_BITS-1:0]);
    s_wide   = (SAMPLE_BITS+1)'(s_cur);
    s_neg    = -s_wide;
    mag      = s_wide[SAMPLE_BITS] ? s_neg[SAMPLE_BITS-1:0] : s_wide[SAMPLE_BITS-1:0];
    diff     = s_wide - (SAMPLE_BITS+1)'(prev_r);
    diff_neg = -diff;
    // the first sample seeds the previous sample, so its step is zero
    if (!seen_r) begin
      step_mag = '0;
    end else if (diff[SAMPLE_BITS]) begin
      step_mag = diff_neg[SAMPLE_BITS-1:0];
    end else begin
      step_mag = diff[SAMPLE_BITS-1:0];
    end
    mag_sq  = PROD_W'(mag) * PROD_W'(mag);
    step_sq = PROD_W'(step_mag) * PROD_W'(step_mag);

    item_nxt.raw     = s1_raw_r;
    item_nxt.sample  = SAMPLE_W'(s_cur);
    item_nxt.mag     = SAMPLE_W'(mag);
    item_nxt.step    = SAMPLE_W'(step_mag);
    item_nxt.mag_sq  = ACC_W'(mag_sq);
    item_nxt.step_sq = ACC_W'(step_sq);
    item_nxt.first   = !seen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      item_valid_r <= 1'b0;
      seen_r       <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (!item_valid_r || item_ready) begin
        item_valid_r <= s1_valid_r;
      end
      if (s1_go) begin
        seen_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_raw_r <= in_ch.sample_in;
    end
    if (s1_go) begin
      prev_r <= s_cur;
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ars_accum.sv
// Statistics registers: min/max/midline, saturating sums, step peak and sample count.
`default_nettype none

module ars_accum #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned ACCUM_BITS  = 64,
  parameter int unsigned COUNT_BITS  = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ars_pkg::ars_item_t item,
  input  logic               item_valid,
  output logic               item_ready,
  ars_out_if.source          out_ch
);
  import ars_pkg::*;

  localparam int unsigned CNT_WIDE_W =
    (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
  localparam logic [ACCUM_BITS-1:0] ACC_UMAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

  // unsigned saturating add: {saturated, value}
  function automatic logic [ACCUM_BITS:0] sat_uadd(input logic [ACCUM_BITS-1:0] acc,
                                                   input acc_u_t add);
    logic [WIDE_W-1:0] sum;
    sum = WIDE_W'(acc) + WIDE_W'(add);
    if (sum > WIDE_W'(ACC_UMAX)) begin
      return {1'b1, ACC_UMAX};
    end
    return {1'b0, sum[ACCUM_BITS-1:0]};
  endfunction

  logic                          go;
  logic                          out_valid_r;
  sample_t                       sample_r;
  logic signed [SAMPLE_BITS-1:0] lo_r, lo_nxt;
  logic signed [SAMPLE_BITS-1:0] hi_r, hi_nxt;
  logic signed [SAMPLE_BITS-1:0] mid_r, mid_nxt;
  logic signed [ACCUM_BITS-1:0]  tot_r, tot_nxt;
  logic        [ACCUM_BITS-1:0]  mag_tot_r, mag_tot_nxt;
  logic        [ACCUM_BITS-1:0]  pow_r, pow_nxt;
  logic        [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic        [ACCUM_BITS-1:0]  step_tot_r, step_tot_nxt;
  logic        [ACCUM_BITS-1:0]  step_pow_r, step_pow_nxt;
  logic        [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                          ovf_r, ovf_nxt;

  logic signed [SAMPLE_BITS-1:0] s;
  logic        [SAMPLE_BITS-1:0] step_n;
  logic signed [SAMPLE_BITS:0]   pair;
  logic signed [ACCUM_BITS:0]    tsum;
  logic                          tot_ovf;
  logic        [ACCUM_BITS:0]    mag_res, pow_res, step_res, step_pow_res;
  logic        [CNT_WIDE_W-1:0]  cnt_wide;

  assign go         = item_valid && item_ready;
  assign item_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    s      = signed'(item.sample[SAMPLE_BITS-1:0]);
    step_n = item.step[SAMPLE_BITS-1:0];

    // the first sample seeds both marks
    lo_nxt  = (item.first || (s < lo_r)) ? s : lo_r;
    hi_nxt  = (item.first || (s > hi_r)) ? s : hi_r;
    pair    = (SAMPLE_BITS+1)'(lo_nxt) + (SAMPLE_BITS+1)'(hi_nxt);
    mid_nxt = pair[SAMPLE_BITS:1];

    tsum    = (ACCUM_BITS+1)'(tot_r) + (ACCUM_BITS+1)'(item.sample);
    tot_ovf = tsum[ACCUM_BITS] ^ tsum[ACCUM_BITS-1];
    if (tot_ovf) begin
      tot_nxt = tsum[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                                 : {1'b0, {(ACCUM_BITS-1){1'b1}}};
    end else begin
      tot_nxt = tsum[ACCUM_BITS-1:0];
    end

    mag_res      = sat_uadd(mag_tot_r, ACC_W'(item.mag));
    pow_res      = sat_uadd(pow_r, item.mag_sq);
    step_res     = sat_uadd(step_tot_r, ACC_W'(item.step));
    step_pow_res = sat_uadd(step_pow_r, item.step_sq);
    mag_tot_nxt  = mag_res[ACCUM_BITS-1:0];
    pow_nxt      = pow_res[ACCUM_BITS-1:0];
    step_tot_nxt = step_res[ACCUM_BITS-1:0];
    step_pow_nxt = step_pow_res[ACCUM_BITS-1:0];

    peak_nxt = (step_n > peak_r) ? step_n : peak_r;
    // count stops at its maximum; the flag is left alone
    cnt_nxt  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    ovf_nxt  = ovf_r | tot_ovf | mag_res[ACCUM_BITS] | pow_res[ACCUM_BITS]
             | step_res[ACCUM_BITS] | step_pow_res[ACCUM_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      mid_r       <= '0;
      tot_r       <= '0;
      mag_tot_r   <= '0;
      pow_r       <= '0;
      peak_r      <= '0;
      step_tot_r  <= '0;
      step_pow_r  <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (item_ready) begin
        out_valid_r <= item_valid;
      end
      if (go) begin
        lo_r       <= lo_nxt;
        hi_r       <= hi_nxt;
        mid_r      <= mid_nxt;
        tot_r      <= tot_nxt;
        mag_tot_r  <= mag_tot_nxt;
        pow_r      <= pow_nxt;
        peak_r     <= peak_nxt;
        step_tot_r <= step_tot_nxt;
        step_pow_r <= step_pow_nxt;
        cnt_r      <= cnt_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sample_r <= item.raw;
    end
  end

  assign cnt_wide = CNT_WIDE_W'(cnt_r);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample_out     = sample_r;
  assign out_ch.minimum        = SAMPLE_W'(lo_r);
  assign out_ch.maximum        = SAMPLE_W'(hi_r);
  assign out_ch.midline        = SAMPLE_W'(mid_r);
  assign out_ch.total_sum      = ACC_W'(tot_r);
  assign out_ch.magnitude_sum  = ACC_W'(mag_tot_r);
  assign out_ch.power_sum      = ACC_W'(pow_r);
  assign out_ch.step_max       = SAMPLE_W'(peak_r);
  assign out_ch.step_sum       = ACC_W'(step_tot_r);
  assign out_ch.step_power_sum = ACC_W'(step_pow_r);
  assign out_ch.samples_seen   = cnt_wide[COUNT_OUT_W-1:0];
  assign out_ch.overflowed     = ovf_r;

endmodule

`default_nettype wire

>>> rtl/audio_running_statistics.sv
// Top level of the audio running statistics block.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid / ready  sample_in (signed 32)
//   out_ch    out  valid / ready  sample_out, minimum, maximum, midline, total_sum,
//                                 magnitude_sum, power_sum, step_max, step_sum,
//                                 step_power_sum, samples_seen, overflowed
//
// One sample per clock while out_ch is not stalled; each result passes through the
// input register, product register and statistics register after its sample is accepted.
// The statistics register is the result register: the reported values are the
// running state after the sample, so a stalled result simply holds it.
// Synchronous active-low reset clears all statistics and the pipeline valids.
// Each stage advances when the stage after it is empty or draining, so a stall
// on out_ch fills the three stages before in_ch drops ready.
`default_nettype none

module audio_running_statistics #(
  parameter int unsigned SAMPLE_BITS = 32,  // 8..32, low bits of sample_in used
  parameter int unsigned ACCUM_BITS  = 64,  // 32..64, saturating sum width
  parameter int unsigned COUNT_BITS  = 48   // 16..64, saturating count width
) (
  input  logic      clk,
  input  logic      rst_n,
  ars_in_if.sink    in_ch,
  ars_out_if.source out_ch
);
  import ars_pkg::*;

  ars_item_t item;        // sample with magnitudes, step and squares formed
  logic      item_valid;
  logic      item_ready;

  // front: register the sample, then form |s|, |s - prev| and both squares
  ars_prep #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  // back: fold the item into the running statistics and present them
  ars_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACCUM_BITS  (ACCUM_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
